// ----- sv/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TAG_BITS_DEFAULT    = 32;
   localparam int PRIO_BITS           = 2;
   localparam int PORT_TAG_BITS       = 32;
   localparam int COUNT_BITS          = 5;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic                 ins_en;
      logic                 rem_en;
      logic [PRIO_BITS-1:0] prio;
   } cell_ctrl_type;

endpackage

// ----- sv/spq_cell.sv -----
// One queue slot: holds an entry, shifts right on insert, left on remove.
module spq_cell import spq_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEFAULT,
   parameter bit IS_HEAD  = 1'b0
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic                 occupied,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  logic [TAG_BITS-1:0]  left_tag,
   input  logic                 left_keep,
   input  logic [PRIO_BITS-1:0] right_prio,
   input  logic [TAG_BITS-1:0]  right_tag,
   output logic [PRIO_BITS-1:0] prio,
   output logic [TAG_BITS-1:0]  tag,
   output logic                 keep
);

   logic [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;
   logic                 after;

   // head yields only to a strictly more urgent code
   assign after = IS_HEAD ? (ctrl.prio >= prio_ff) : (ctrl.prio > prio_ff);
   assign keep  = occupied && after;

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.ins_en) begin
         if (keep) begin
            prio_in = prio_ff;
            tag_in  = tag_ff;
         end else if (left_keep) begin
            prio_in = ctrl.prio;
            tag_in  = new_tag;
         end else begin
            prio_in = left_prio;
            tag_in  = left_tag;
         end
      end else if (ctrl.rem_en) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule

// ----- sv/sorted_priority_queue_unit.sv -----
// Sorted priority queue: top level with the cell chain and result register.
//
//   channel   ports                         handshake
//   request   req_mode/priority_req/tag     start, busy (busy held low)
//   result    rsp_status .. rsp_count       rsp_valid strobe, one cycle
//
// One item per cycle: every cell compares and shifts in parallel in the
// cycle the item is accepted; the result appears on the next cycle.
// Reset clears the occupancy and the result strobe; slot contents are
// not cleared and are read only below the occupancy.
// The receiver cannot stall; busy stays low.
module sorted_priority_queue_unit import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int TAG_BITS    = TAG_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [PRIO_BITS-1:0]     req_priority_req,
   input  logic [PORT_TAG_BITS-1:0] req_tag,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_out_valid,
   output logic [PRIO_BITS-1:0]     rsp_out_priority,
   output logic [PORT_TAG_BITS-1:0] rsp_out_tag,
   output logic [COUNT_BITS-1:0]    rsp_count
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                     accept;
   logic [CNT_W-1:0]         occ_ff, occ_in;
   logic                     is_full, is_empty;
   cell_ctrl_type            ctrl;
   logic [TAG_BITS-1:0]      new_tag;
   logic [TAG_BITS+PORT_TAG_BITS-1:0] new_tag_wide;

   logic [PRIO_BITS-1:0] cprio [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]  ctag  [QUEUE_DEPTH];
   logic                 ckeep [QUEUE_DEPTH];

   logic                     rsp_valid_ff;
   logic [1:0]               status_ff, status_in;
   logic                     oval_ff, oval_in;
   logic [PRIO_BITS-1:0]     oprio_ff, oprio_in;
   logic [PORT_TAG_BITS-1:0] otag_ff, otag_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [TAG_BITS-1:0]      head_tag;
   logic [TAG_BITS+PORT_TAG_BITS-1:0] head_tag_wide;
   logic [CNT_W+COUNT_BITS-1:0]       cnt_wide;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (occ_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (occ_ff == '0);

   assign new_tag_wide = {{TAG_BITS{1'b0}}, req_tag};
   assign new_tag      = new_tag_wide[TAG_BITS-1:0];

   assign ctrl.ins_en = accept && (req_mode == MODE_INSERT) && !is_full;
   assign ctrl.rem_en = accept && (req_mode == MODE_REMOVE) && !is_empty;
   assign ctrl.prio   = req_priority_req;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 l_keep;
      logic [PRIO_BITS-1:0] l_prio, r_prio;
      logic [TAG_BITS-1:0]  l_tag, r_tag;
      logic                 occ;

      assign occ = (CNT_W'(i) < occ_ff);
      if (i == 0) begin : g_head
         assign l_keep = 1'b0;
         assign l_prio = req_priority_req;
         assign l_tag  = new_tag;
      end else begin : g_body
         assign l_keep = ckeep[i-1];
         assign l_prio = cprio[i-1];
         assign l_tag  = ctag[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign r_prio = cprio[i];
         assign r_tag  = ctag[i];
      end else begin : g_mid
         assign r_prio = cprio[i+1];
         assign r_tag  = ctag[i+1];
      end

      spq_cell #(
         .TAG_BITS (TAG_BITS),
         .IS_HEAD  (i == 0)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .new_tag    (new_tag),
         .occupied   (occ),
         .left_prio  (l_prio),
         .left_tag   (l_tag),
         .left_keep  (l_keep),
         .right_prio (r_prio),
         .right_tag  (r_tag),
         .prio       (cprio[i]),
         .tag        (ctag[i]),
         .keep       (ckeep[i])
      );
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.ins_en) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (ctrl.rem_en) begin
         occ_in = occ_ff - CNT_W'(1);
      end
   end

   assign cnt_wide = {{COUNT_BITS{1'b0}}, occ_in};

   always_comb begin
      status_in = STATUS_OK;
      oval_in   = 1'b1;
      oprio_in  = cprio[0];
      head_tag  = ctag[0];
      cnt_in    = cnt_wide[COUNT_BITS-1:0];
      if (req_mode == MODE_INSERT) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else if (!ckeep[0]) begin
            oprio_in = req_priority_req;
            head_tag = new_tag;
         end
      end else if (is_empty) begin
         status_in = STATUS_EMPTY;
         oval_in   = 1'b0;
         oprio_in  = '0;
         head_tag  = '0;
      end
   end

   assign head_tag_wide = {{PORT_TAG_BITS{1'b0}}, head_tag};
   assign otag_in       = head_tag_wide[PORT_TAG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         oval_ff   <= oval_in;
         oprio_ff  <= oprio_in;
         otag_ff   <= otag_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_valid    = oval_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_out_tag      = otag_ff;
   assign rsp_count        = cnt_ff;

endmodule

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker import spq_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     req_mode,
   input logic                     rsp_valid,
   input logic [1:0]               rsp_status,
   input logic                     rsp_out_valid,
   input logic [PRIO_BITS-1:0]     rsp_out_priority,
   input logic [PORT_TAG_BITS-1:0] rsp_out_tag,
   input logic [COUNT_BITS-1:0]    rsp_count
);

   // one result per accepted item, in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid == $past(start && !busy)))
      else $error("result strobe does not follow accepted item");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (!rsp_out_valid && rsp_count == '0 && rsp_out_priority == '0 && rsp_out_tag == '0))
      else $error("empty status with nonzero result");

   a_empty_on_remove: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |-> ($past(req_mode) == MODE_REMOVE))
      else $error("empty status on insert");

   a_ok_has_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OK || rsp_status == STATUS_FULL)) |-> rsp_out_valid)
      else $error("entry missing on ok or full result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_EMPTY))
      else $error("undefined status code");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_out_valid    (rsp_out_valid),
   .rsp_out_priority (rsp_out_priority),
   .rsp_out_tag      (rsp_out_tag),
   .rsp_count        (rsp_count)
);
